### rtl/core/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg: shared types and constants for the MIPS subset executor
// Item layouts, opcode and funct codes, register file geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package msie_pkg;

  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned XLEN     = 32;

  localparam logic [31:0] PC_RESET = 32'h0040_0000;

  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_BNE   = 6'b000101;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_ANDI  = 6'b001100;

  localparam logic [5:0] FN_SLL   = 6'b000000;
  localparam logic [5:0] FN_SRL   = 6'b000010;
  localparam logic [5:0] FN_ADD   = 6'b100000;

  localparam logic MODE_EXEC = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction_word;
    logic [4:0]  reg_index;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] write_value;
    logic        branch_taken;
    logic        halted;
    logic [31:0] read_value;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/msie_ram.sv
// ----------------------------------------------------------------------------
// msie_ram: generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module msie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mips_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_unit: MIPS32 subset execute unit
// Runs add, sll, srl, addi, andi, beq and bne against a 32-entry register
// file and a program counter; read mode returns one register.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a result held by rsp_ready stalls it; the
// accept edge registers the item and reads both register file operands from
// a RAM with registered read, and the edge that advances the item registers
// the result from one pass of decode, add, shift or compare, and writes back.
// The write of the item ahead is forwarded, so dependent items need no gap. The
// register file needs no clearing pass after reset: a valid bit per entry
// makes unwritten registers read zero, and register 0 is never written.
`default_nettype none

module mips_subset_instruction_executor_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire msie_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output msie_pkg::rsp_t     rsp
);

  import msie_pkg::*;

  localparam int unsigned AW = $clog2(NUM_REGS);

  // stage registers
  logic            s1_valid;
  req_t            s1_req;
  logic            a_fwd, b_fwd;
  logic            a_live, b_live;
  logic [XLEN-1:0] fwd_value;
  logic [31:0]     pc;
  logic [NUM_REGS-1:0] rf_valid;

  logic            accept, adv;
  logic [AW-1:0]   addr_a, addr_b;
  logic [XLEN-1:0] ram_a, ram_b;
  logic [XLEN-1:0] opnd_a, opnd_b;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [XLEN-1:0] wr_value;
  logic            pc_load;
  logic [31:0]     pc_next;
  rsp_t            rsp_next;

  assign adv       = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || adv;
  assign accept    = req_valid && req_ready;

  assign addr_a = (req.mode == MODE_READ) ? req.reg_index : req.instruction_word[25:21];
  assign addr_b = req.instruction_word[20:16];

  msie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_value),
    .re      (accept),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // capture the item with the write landing on the same edge as a bypass
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= req;
      a_fwd     <= wr_en && (wr_addr == addr_a);
      b_fwd     <= wr_en && (wr_addr == addr_b);
      a_live    <= rf_valid[addr_a];
      b_live    <= rf_valid[addr_b];
      fwd_value <= wr_value;
    end
  end

  assign opnd_a = a_fwd ? fwd_value : (a_live ? ram_a : '0);
  assign opnd_b = b_fwd ? fwd_value : (b_live ? ram_b : '0);

  always_comb begin
    logic [31:0]     word;
    logic [5:0]      op;
    logic [5:0]      fn;
    logic [4:0]      sh;
    logic [15:0]     imm;
    logic [31:0]     imm_sx;
    logic            do_write;
    logic [AW-1:0]   target;
    logic [XLEN-1:0] value;
    logic            taken;
    logic [31:0]     seq_pc;

    word     = s1_req.instruction_word;
    op       = word[31:26];
    fn       = word[5:0];
    sh       = word[10:6];
    imm      = word[15:0];
    imm_sx   = {{16{imm[15]}}, imm};
    do_write = 1'b0;
    target   = word[15:11];
    value    = '0;
    taken    = 1'b0;
    seq_pc   = pc + 32'd4;
    rsp_next = '0;
    pc_next  = pc;
    pc_load  = 1'b0;

    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD: begin
            do_write = 1'b1;
            value    = opnd_a + opnd_b;
          end
          FN_SLL: begin
            do_write = 1'b1;
            value    = opnd_b << sh;
          end
          FN_SRL: begin
            do_write = 1'b1;
            value    = opnd_b >> sh;
          end
          default: do_write = 1'b0;
        endcase
      end
      OP_ADDI: begin
        do_write = 1'b1;
        target   = word[20:16];
        value    = opnd_a + imm_sx;
      end
      OP_ANDI: begin
        do_write = 1'b1;
        target   = word[20:16];
        value    = opnd_a & {16'd0, imm};
      end
      OP_BEQ:  taken = (opnd_a == opnd_b);
      OP_BNE:  taken = (opnd_a != opnd_b);
      default: taken = 1'b0;
    endcase

    if (s1_req.mode == MODE_READ) begin
      rsp_next.next_pc    = pc;
      rsp_next.read_value = opnd_a;
    end else if (word == '0) begin
      rsp_next.next_pc = pc;
      rsp_next.halted  = 1'b1;
    end else begin
      pc_load = 1'b1;
      pc_next = taken ? seq_pc + {imm_sx[29:0], 2'b00} : seq_pc;
      rsp_next.next_pc      = pc_next;
      rsp_next.branch_taken = taken;
      // drop writes to register zero
      if (do_write && (target != '0)) begin
        rsp_next.reg_written = 1'b1;
        rsp_next.dest_index  = target;
        rsp_next.write_value = value;
      end
    end
  end

  assign wr_en    = adv && rsp_next.reg_written;
  assign wr_addr  = rsp_next.dest_index;
  assign wr_value = rsp_next.write_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= PC_RESET;
      rf_valid <= '0;
    end else if (adv) begin
      if (pc_load) begin
        pc <= pc_next;
      end
      if (wr_en) begin
        rf_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr != '0))
    else $error("write to register zero");

  a_zero_never_valid: assert property (@(posedge clk) disable iff (rst)
    !rf_valid[0])
    else $error("register zero marked written");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_req)))
    else $error("stalled item lost or changed");

  a_halt_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.halted) |-> (!rsp.reg_written && !rsp.branch_taken))
    else $error("halt result carries a write or branch");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !rsp_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

### sim/msie_exec_checker.sv
// ----------------------------------------------------------------------------
// msie_exec_checker: result checker for the MIPS subset executor
// Watches both channels, runs its own copy of the register file and program
// counter for every accepted item, and compares each result field by field
// with the oldest expectation. Reports a failure tally and the number of
// results still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module msie_exec_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire msie_pkg::req_t req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire msie_pkg::rsp_t rsp,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);

  import msie_pkg::*;

  logic [31:0] gpr [NUM_REGS];
  logic [31:0] pc_q;
  rsp_t        owed_q [$];
  rsp_t        want;
  int unsigned fail_tally;
  int unsigned result_idx;

  function automatic logic [31:0] gpr_read(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gpr[idx];
  endfunction

  // Execute one item on the shadow state and return what the block must report.
  function automatic rsp_t execute_item(input req_t item);
    rsp_t        res;
    logic [31:0] w;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm_sx;
    logic [31:0] nxt;
    logic [31:0] val;
    logic [4:0]  tgt;
    logic        wr_en;
    res = '0;
    w   = item.instruction_word;
    if (item.mode == MODE_READ) begin
      res.read_value = gpr_read(item.reg_index);
    end else if (w == 32'd0) begin
      res.halted = 1'b1;
    end else begin
      opc    = w[31:26];
      rs     = w[25:21];
      rt     = w[20:16];
      rd     = w[15:11];
      sh     = w[10:6];
      fn     = w[5:0];
      imm_sx = {{16{w[15]}}, w[15:0]};
      a      = gpr_read(rs);
      b      = gpr_read(rt);
      nxt    = pc_q + 32'd4;
      wr_en  = 1'b0;
      tgt    = 5'd0;
      val    = 32'd0;
      case (opc)
        OP_RTYPE: begin
          tgt = rd;
          case (fn)
            FN_ADD: begin
              wr_en = 1'b1;
              val   = a + b;
            end
            FN_SLL: begin
              wr_en = 1'b1;
              val   = b << sh;
            end
            FN_SRL: begin
              wr_en = 1'b1;
              val   = b >> sh;
            end
            default: ;
          endcase
        end
        OP_ADDI: begin
          wr_en = 1'b1;
          tgt   = rt;
          val   = a + imm_sx;
        end
        OP_ANDI: begin
          wr_en = 1'b1;
          tgt   = rt;
          val   = a & {16'd0, w[15:0]};
        end
        OP_BEQ, OP_BNE: begin
          if ((opc == OP_BEQ) == (a == b)) begin
            res.branch_taken = 1'b1;
            nxt = nxt + (imm_sx << 2);
          end
        end
        default: ;
      endcase
      // drop writes to register zero
      if (wr_en && tgt != 5'd0) begin
        gpr[tgt]        = val;
        res.reg_written = 1'b1;
        res.dest_index  = tgt;
        res.write_value = val;
      end
      pc_q = nxt;
    end
    res.next_pc = pc_q;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = 32'd0;
      pc_q = PC_RESET;
      owed_q.delete();
      fail_tally = 0;
      result_idx = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("result %0d: no item outstanding, got next_pc=%h rval=%h",
                     result_idx, rsp.next_pc, rsp.read_value);
        end else begin
          want = owed_q.pop_front();
          if (rsp.next_pc !== want.next_pc || rsp.reg_written !== want.reg_written ||
              rsp.dest_index !== want.dest_index || rsp.write_value !== want.write_value ||
              rsp.branch_taken !== want.branch_taken || rsp.halted !== want.halted ||
              rsp.read_value !== want.read_value) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("result %0d exp: pc=%h wr=%b dst=%0d wval=%h br=%b halt=%b rval=%h",
                       result_idx, want.next_pc, want.reg_written, want.dest_index,
                       want.write_value, want.branch_taken, want.halted, want.read_value);
              $display("result %0d got: pc=%h wr=%b dst=%0d wval=%h br=%b halt=%b rval=%h",
                       result_idx, rsp.next_pc, rsp.reg_written, rsp.dest_index,
                       rsp.write_value, rsp.branch_taken, rsp.halted, rsp.read_value);
            end
          end
        end
        result_idx++;
      end
      if (req_valid && req_ready) owed_q.push_back(execute_item(req));
      mismatches  <= fail_tally;
      outstanding <= owed_q.size();
    end
  end

endmodule

`default_nettype wire

### sim/tb_mips_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_executor_unit: testbench for the MIPS subset unit
// Drives a directed set of corner instructions, then random programs of
// well-formed instructions mixed with reads, halts and raw words, under
// several sender and receiver idle mixes. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mips_subset_instruction_executor_unit;

  import msie_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS  = 420;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  req_t        req       = '0;
  logic        req_ready;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned random_sent   = 0;

  mips_subset_instruction_executor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  msie_exec_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // End the run when neither channel moves for far longer than any idle stretch.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("mips_subset_instruction_executor_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic req_t exec_req(input logic [31:0] word);
    req_t item;
    item.mode             = MODE_EXEC;
    item.instruction_word = word;
    item.reg_index        = 5'($urandom_range(31));
    return item;
  endfunction

  function automatic req_t read_req(input logic [4:0] idx, input logic [31:0] word);
    req_t item;
    item.mode             = MODE_READ;
    item.instruction_word = word;
    item.reg_index        = idx;
    return item;
  endfunction

  // Favor a few low registers so results feed later instructions.
  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    if ($urandom_range(1) == 0) r = 5'($urandom_range(7));
    else r = 5'($urandom_range(31));
    return r;
  endfunction

  function automatic logic [15:0] pick_imm();
    logic [15:0] imm;
    case ($urandom_range(9))
      0:       imm = 16'h0000;
      1:       imm = 16'h7FFF;
      2:       imm = 16'h8000;
      3:       imm = 16'hFFFF;
      4:       imm = 16'h0001;
      default: imm = 16'($urandom_range(16'hFFFF));
    endcase
    return imm;
  endfunction

  function automatic req_t random_item();
    int unsigned sel;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [15:0] imm;
    sel = $urandom_range(99);
    rs  = pick_reg();
    rt  = pick_reg();
    rd  = pick_reg();
    sh  = 5'($urandom_range(31));
    fn  = 6'($urandom_range(63));
    imm = pick_imm();
    if (sel < 10) return read_req(pick_reg(), $urandom());
    if (sel < 13) return exec_req(32'd0);
    if (sel < 20) return exec_req($urandom());
    if (sel < 23) return exec_req(enc_r(rs, rt, rd, sh, fn));
    case ($urandom_range(6))
      0: return exec_req(enc_r(rs, rt, rd, sh, FN_ADD));
      1: return exec_req(enc_r(rs, rt, rd, sh, FN_SLL));
      2: return exec_req(enc_r(rs, rt, rd, sh, FN_SRL));
      3: return exec_req(enc_i(OP_ADDI, rs, rt, imm));
      4: return exec_req(enc_i(OP_ANDI, rs, rt, imm));
      default: begin
        // bias branches toward equal operands so both outcomes show up
        if ($urandom_range(4) < 2) rt = ($urandom_range(1) == 0) ? rs : 5'd0;
        return exec_req(enc_i(($urandom_range(1) == 0) ? OP_BEQ : OP_BNE, rs, rt, imm));
      end
    endcase
  endfunction

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Hold the sender until every result owed has been checked.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      // now and then walk the pc backward far enough to wrap it
      if (random_sent % 400 == 50)
        repeat (40) send_item(exec_req(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000)));
      send_item(random_item());
      random_sent++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // corner instructions, no idling
    send_item(read_req(5'd0, 32'hFFFF_FFFF));
    send_item(read_req(5'd31, $urandom()));
    send_item(exec_req(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF)));
    send_item(exec_req(enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000)));
    send_item(exec_req(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD)));
    send_item(exec_req(enc_r(5'd3, 5'd3, 5'd4, 5'd0, FN_ADD)));
    send_item(exec_req(enc_i(OP_ADDI, 5'd3, 5'd5, 16'h0001)));
    send_item(exec_req(enc_r(5'd0, 5'd3, 5'd6, 5'd31, FN_SLL)));
    send_item(exec_req(enc_r(5'd0, 5'd3, 5'd7, 5'd31, FN_SRL)));
    send_item(exec_req(enc_r(5'd0, 5'd1, 5'd8, 5'd0, FN_SLL)));
    send_item(exec_req(enc_r(5'd0, 5'd2, 5'd9, 5'd0, FN_SRL)));
    send_item(exec_req(enc_i(OP_ANDI, 5'd3, 5'd10, 16'hFFFF)));
    send_item(exec_req(enc_i(OP_ANDI, 5'd3, 5'd11, 16'h0000)));
    send_item(exec_req(enc_i(OP_ADDI, 5'd1, 5'd0, 16'h0005)));
    send_item(exec_req(enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_ADD)));
    send_item(exec_req(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF)));
    send_item(exec_req(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h7FFF)));
    send_item(exec_req(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF)));
    send_item(exec_req(enc_i(OP_BNE, 5'd0, 5'd0, 16'h8000)));
    send_item(exec_req(enc_i(OP_BEQ, 5'd3, 5'd3, 16'h8000)));
    send_item(exec_req(32'd0));
    send_item(exec_req(32'hFFFF_FFFF));
    send_item(exec_req(enc_r(5'd1, 5'd2, 5'd3, 5'd0, 6'h3F)));
    send_item(read_req(5'd0, 32'd0));
    send_item(read_req(5'd3, $urandom()));
    drain_results();

    run_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 65;
    rsp_stall_pct = 0;
    run_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 0;
    rsp_stall_pct = 65;
    run_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 18;
    rsp_stall_pct = 18;
    run_random(PHASE_ITEMS);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mips_subset_instruction_executor_unit test passed");
    end else begin
      $display("mips_subset_instruction_executor_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/core/msie_pkg.sv
rtl/core/msie_ram.sv
rtl/core/mips_subset_instruction_executor_unit.sv
sim/msie_exec_checker.sv
sim/tb_mips_subset_instruction_executor_unit.sv
